>>> hw/rtl/tpsc_pkg.sv
// Package for the triangle plane set clipper: widths, codes, shared types.
// No dependencies.
package tpsc_pkg;

    localparam int CoordW     = 32;
    localparam int NormW      = 16;
    localparam int DistW      = 64;
    localparam int TBits      = 30;
    localparam int PolyCap    = 6;
    localparam int MaxPlanes  = 3;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 48;

    localparam logic [CfgIdxW-1:0] RegPlaneCount = 3'd0;
    localparam logic [CfgIdxW-1:0] RegNormal0    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegOffset0    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegNormal1    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOffset1    = 3'd4;
    localparam logic [CfgIdxW-1:0] RegNormal2    = 3'd5;
    localparam logic [CfgIdxW-1:0] RegOffset2    = 3'd6;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [DistW-1:0]  t_dist;
    typedef logic [2:0]               t_pidx;   // polygon slot index 0..5
    typedef logic [2:0]               t_pcnt;   // polygon count 0..6

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vtx;

    typedef struct packed {
        t_vtx a;
        t_vtx b;
        t_vtx c;
        logic last;
    } t_tri;

    // channel payloads
    typedef struct packed {
        t_coord vert0_x;
        t_coord vert0_y;
        t_coord vert0_z;
        t_coord vert1_x;
        t_coord vert1_y;
        t_coord vert1_z;
        t_coord vert2_x;
        t_coord vert2_y;
        t_coord vert2_z;
    } t_tri_in;

    typedef struct packed {
        t_coord out_a_x;
        t_coord out_a_y;
        t_coord out_a_z;
        t_coord out_b_x;
        t_coord out_b_y;
        t_coord out_b_z;
        t_coord out_c_x;
        t_coord out_c_y;
        t_coord out_c_z;
        logic   last_triangle;
    } t_tri_out;

    // controller to datapath commands
    typedef enum logic [3:0] {
        CMD_NOP   = 4'd0,
        CMD_LOAD  = 4'd1,   // load input triangle into polygon buffer
        CMD_DIST  = 4'd2,   // compute distance of slot sel_a, store
        CMD_KEEP  = 4'd3,   // append src slot sel_a to destination
        CMD_DIVST = 4'd4,   // start division for edge sel_a -> sel_b
        CMD_DIVSP = 4'd5,   // one division step
        CMD_MUL   = 4'd6,   // interpolation product for axis
        CMD_APPX  = 4'd7,   // append interpolated vertex
        CMD_SWAP  = 4'd8,   // destination becomes source
        CMD_EMIT  = 4'd9    // load output register with fan triangle
    } t_cmd;

    typedef struct packed {
        t_cmd  cmd;
        t_pidx sel_a;
        t_pidx sel_b;
        logic [1:0] plane;
        logic [1:0] axis;
        logic  last;
    } t_ctl;

    typedef struct packed {
        t_pcnt src_n;
        logic  d_a_ge0;
        logic  d_a_gt0;
        logic  d_b_ge0;
        logic  d_b_gt0;
    } t_sts;

endpackage

>>> hw/rtl/tpsc_stream_if.sv
// Valid/ready channel interface carrying a payload of type T.
// No dependencies; the payload type is given as a parameter.
interface tpsc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tpsc_datapath.sv
// Clipper datapath: polygon buffers, distance unit, serial divider, interpolator.
// Depends on tpsc_pkg.
module tpsc_datapath (
    input  logic             i_clk,
    input  tpsc_pkg::t_ctl   i_ctl,
    input  tpsc_pkg::t_vtx   i_in_v [3],
    input  logic [15:0]      i_norm [3][3],
    input  logic [31:0]      i_offs [3],
    output tpsc_pkg::t_sts   o_sts,
    output tpsc_pkg::t_tri   o_tri
);
    import tpsc_pkg::*;

    t_vtx  r_src [PolyCap];
    t_vtx  r_dst [PolyCap];
    t_dist r_d   [PolyCap];
    t_pcnt r_src_n, r_dst_n;
    t_pidx r_lo_i, r_hi_i;
    logic [63:0] r_num, r_den;
    logic [TBits-1:0] r_t;
    t_coord r_res [3];
    t_tri  r_tri;

    // distance: three 32x16 products summed minus shifted offset
    t_vtx  w_va;
    logic signed [47:0] w_px, w_py, w_pz;
    t_dist w_dist;
    always_comb begin
        w_va = r_src[i_ctl.sel_a];
        w_px = w_va.x * $signed(i_norm[i_ctl.plane][0]);
        w_py = w_va.y * $signed(i_norm[i_ctl.plane][1]);
        w_pz = w_va.z * $signed(i_norm[i_ctl.plane][2]);
        w_dist = t_dist'(w_px) + t_dist'(w_py) + t_dist'(w_pz)
               - (t_dist'($signed(i_offs[i_ctl.plane])) <<< 14);
    end

    // interpolation for one axis
    t_vtx w_lo, w_hi;
    logic signed [32:0] w_delta;
    logic signed [64:0] w_prod;
    t_coord w_lc, w_hc;
    always_comb begin
        w_lo = r_src[r_lo_i];
        w_hi = r_src[r_hi_i];
        unique case (i_ctl.axis)
            2'd0:    begin w_lc = w_lo.x; w_hc = w_hi.x; end
            2'd1:    begin w_lc = w_lo.y; w_hc = w_hi.y; end
            default: begin w_lc = w_lo.z; w_hc = w_hi.z; end
        endcase
        w_delta = 33'(w_hc) - 33'(w_lc);
        w_prod  = w_delta * $signed({1'b0, r_t}) + (65'sd1 <<< (TBits - 1));
    end

    logic [63:0] w_num2;
    always_comb w_num2 = {r_num[62:0], 1'b0};

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.cmd)
            CMD_LOAD: begin
                for (int i = 0; i < 3; i++) r_src[i] <= i_in_v[i];
                r_src_n <= 3'd3;
                r_dst_n <= 3'd0;
            end
            CMD_DIST: r_d[i_ctl.sel_a] <= w_dist;
            CMD_KEEP: if (r_dst_n < 3'(PolyCap)) begin
                r_dst[r_dst_n] <= r_src[i_ctl.sel_a];
                r_dst_n <= r_dst_n + 3'd1;
            end
            CMD_DIVST: begin
                // lower distance endpoint is the base
                if (r_d[i_ctl.sel_a] < r_d[i_ctl.sel_b]) begin
                    r_lo_i <= i_ctl.sel_a; r_hi_i <= i_ctl.sel_b;
                    r_num <= 64'(-r_d[i_ctl.sel_a]);
                    r_den <= 64'(r_d[i_ctl.sel_b] - r_d[i_ctl.sel_a]);
                end else begin
                    r_lo_i <= i_ctl.sel_b; r_hi_i <= i_ctl.sel_a;
                    r_num <= 64'(-r_d[i_ctl.sel_b]);
                    r_den <= 64'(r_d[i_ctl.sel_a] - r_d[i_ctl.sel_b]);
                end
                r_t <= '0;
            end
            CMD_DIVSP: begin
                if (w_num2 >= r_den) begin
                    r_num <= w_num2 - r_den;
                    r_t <= {r_t[TBits-2:0], 1'b1};
                end else begin
                    r_num <= w_num2;
                    r_t <= {r_t[TBits-2:0], 1'b0};
                end
            end
            CMD_MUL: r_res[i_ctl.axis] <= w_lc + t_coord'(w_prod >>> TBits);
            CMD_APPX: if (r_dst_n < 3'(PolyCap)) begin
                r_dst[r_dst_n] <= '{x: r_res[0], y: r_res[1], z: r_res[2]};
                r_dst_n <= r_dst_n + 3'd1;
            end
            CMD_SWAP: begin
                for (int i = 0; i < PolyCap; i++) r_src[i] <= r_dst[i];
                r_src_n <= r_dst_n;
                r_dst_n <= 3'd0;
            end
            CMD_EMIT: begin
                r_tri.a <= r_src[0];
                r_tri.b <= r_src[i_ctl.sel_a];
                r_tri.c <= r_src[i_ctl.sel_b];
                r_tri.last <= i_ctl.last;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.src_n   = r_src_n;
        o_sts.d_a_ge0 = !r_d[i_ctl.sel_a][DistW-1];
        o_sts.d_a_gt0 = !r_d[i_ctl.sel_a][DistW-1] && (r_d[i_ctl.sel_a] != '0);
        o_sts.d_b_ge0 = !r_d[i_ctl.sel_b][DistW-1];
        o_sts.d_b_gt0 = !r_d[i_ctl.sel_b][DistW-1] && (r_d[i_ctl.sel_b] != '0);
    end
    assign o_tri = r_tri;
endmodule

>>> hw/rtl/tpsc_ctrl.sv
// Clipper controller: sequences distance, edge, divide, interpolate and fan emit steps.
// Depends on tpsc_pkg.
module tpsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  logic [1:0]      i_plane_count,
    input  tpsc_pkg::t_sts  i_sts,
    output tpsc_pkg::t_ctl  o_ctl
);
    import tpsc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIST  = 10'b0000000010,
        S_EDGE  = 10'b0000000100,
        S_DIVST = 10'b0000001000,
        S_DIVSP = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_APPX  = 10'b0001000000,
        S_SWAP  = 10'b0010000000,
        S_EMIT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_pidx  r_i, n_i;
    logic [1:0] r_k, n_k, r_ax, n_ax;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] w_used;
    t_pidx  w_j;

    assign w_used = i_plane_count;  // 2-bit count never exceeds three
    assign w_j = (r_i + 3'd1 == i_sts.src_n) ? 3'd0 : r_i + 3'd1;

    always_comb begin
        n_state = r_state; n_i = r_i; n_k = r_k; n_ax = r_ax; n_cnt = r_cnt;
        o_ctl = '{cmd: CMD_NOP, sel_a: r_i, sel_b: w_j, plane: r_k, axis: r_ax,
                  last: 1'b0};
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_k = 2'd0; n_i = 3'd0;
                    n_state = (w_used == 2'd0) ? S_EMIT : S_DIST;
                    n_i = (w_used == 2'd0) ? 3'd1 : 3'd0;
                end
            end
            S_DIST: begin
                o_ctl.cmd = CMD_DIST;
                if (r_i + 3'd1 >= i_sts.src_n) begin
                    n_i = 3'd0; n_state = S_EDGE;
                end else n_i = r_i + 3'd1;
            end
            S_EDGE: begin
                if (r_i >= i_sts.src_n) begin
                    n_state = S_SWAP;
                end else if (i_sts.d_a_ge0) begin
                    o_ctl.cmd = CMD_KEEP;
                    if (!i_sts.d_b_ge0 && i_sts.d_a_gt0) n_state = S_DIVST;
                    else n_i = r_i + 3'd1;
                end else if (i_sts.d_b_gt0) begin
                    n_state = S_DIVST;
                end else n_i = r_i + 3'd1;
            end
            S_DIVST: begin
                o_ctl.cmd = CMD_DIVST;
                n_cnt = 5'd0; n_state = S_DIVSP;
            end
            S_DIVSP: begin
                o_ctl.cmd = CMD_DIVSP;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(TBits - 1)) begin
                    n_ax = 2'd0; n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.cmd = CMD_MUL;
                n_ax = r_ax + 2'd1;
                if (r_ax == 2'd2) n_state = S_APPX;
            end
            S_APPX: begin
                o_ctl.cmd = CMD_APPX;
                n_i = r_i + 3'd1; n_state = S_EDGE;
            end
            S_SWAP: begin
                o_ctl.cmd = CMD_SWAP;
                n_i = 3'd0;
                if (r_k + 2'd1 == w_used) begin
                    n_i = 3'd1; n_state = S_EMIT;
                end else begin
                    n_k = r_k + 2'd1; n_state = S_DIST;
                end
            end
            S_EMIT: begin
                // fan triangle (0, i, i+1); nothing when fewer than three remain
                if (r_i + 3'd1 >= i_sts.src_n) n_state = S_IDLE;
                else begin
                    o_ctl.cmd = CMD_EMIT;
                    o_ctl.sel_b = r_i + 3'd1;
                    o_ctl.last = (r_i + 3'd2 == i_sts.src_n);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_i = r_i + 3'd1; n_state = S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_i <= '0; r_k <= '0; r_ax <= '0; r_cnt <= '0;
        end else begin
            r_state <= n_state; r_i <= n_i; r_k <= n_k; r_ax <= n_ax; r_cnt <= n_cnt;
        end
    end
endmodule

>>> hw/rtl/triangle_plane_set_clipper_top.sv
// Triangle clipper: one triangle per transfer, up to four fan triangles out.
// Sequence: load, then per plane a distance for each vertex, an edge pass that divides and interpolates
// at each crossing, and a swap; then the fan results are offered one at a time.
// Flow: one triangle at a time; the next input is taken only after the last result of the
// previous one, and each crossing runs the 30-step divider.
// Reset: synchronous active low; control and configuration registers cleared, plane count zero.
module triangle_plane_set_clipper_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpsc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [tpsc_pkg::CfgDataW-1:0] i_cfg_data,
    tpsc_stream_if.sink                   s_in,
    tpsc_stream_if.source                 m_out
);
    import tpsc_pkg::*;

    logic [1:0]  r_pcount;
    logic [15:0] r_norm [3][3];
    logic [31:0] r_offs [3];
    logic [1:0]  w_cfg_k;
    t_ctl w_ctl;
    t_sts w_sts;
    t_tri w_tri;
    t_vtx w_in [3];

    assign w_cfg_k = 2'((i_cfg_idx - 3'd1) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= '0;
            for (int k = 0; k < 3; k++) begin
                r_offs[k] <= '0;
                for (int a = 0; a < 3; a++) r_norm[k][a] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == RegPlaneCount) r_pcount <= i_cfg_data[1:0];
            else if (i_cfg_idx <= RegOffset2) begin
                if (i_cfg_idx[0]) begin
                    for (int a = 0; a < 3; a++)
                        r_norm[w_cfg_k][a] <= i_cfg_data[16*a +: 16];
                end else r_offs[w_cfg_k] <= i_cfg_data[31:0];
            end
        end
    end

    assign w_in[0] = '{x: s_in.data.vert0_x, y: s_in.data.vert0_y, z: s_in.data.vert0_z};
    assign w_in[1] = '{x: s_in.data.vert1_x, y: s_in.data.vert1_y, z: s_in.data.vert1_z};
    assign w_in[2] = '{x: s_in.data.vert2_x, y: s_in.data.vert2_y, z: s_in.data.vert2_z};

    tpsc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_in.valid), .o_in_ready(s_in.ready),
        .o_out_valid(m_out.valid), .i_out_ready(m_out.ready),
        .i_plane_count(r_pcount), .i_sts(w_sts), .o_ctl(w_ctl)
    );

    tpsc_datapath u_dp (
        .i_clk, .i_ctl(w_ctl), .i_in_v(w_in), .i_norm(r_norm), .i_offs(r_offs),
        .o_sts(w_sts), .o_tri(w_tri)
    );

    assign m_out.data.out_a_x = w_tri.a.x;
    assign m_out.data.out_a_y = w_tri.a.y;
    assign m_out.data.out_a_z = w_tri.a.z;
    assign m_out.data.out_b_x = w_tri.b.x;
    assign m_out.data.out_b_y = w_tri.b.y;
    assign m_out.data.out_b_z = w_tri.b.z;
    assign m_out.data.out_c_x = w_tri.c.x;
    assign m_out.data.out_c_y = w_tri.c.y;
    assign m_out.data.out_c_z = w_tri.c.z;
    assign m_out.data.last_triangle = w_tri.last;
endmodule

>>> hw/rtl/tpsc_checker.sv
// Port-level checks for the clipper top level, attached by bind.
// Depends on the top level's ports only.
module tpsc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_last
);
    // no new triangle while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready) else $error("input ready during output");
    // pending result's valid and last flag hold until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_last))
        else $error("output dropped");
    // after a non-last transfer no input is taken next cycle
    a_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> !i_in_ready)
        else $error("triangle sequence cut short");
    // after reset the block is ready
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready || !i_rst_n) else $error("not idle after reset");
endmodule

bind triangle_plane_set_clipper_top tpsc_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid(s_in.valid), .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready),
    .i_out_last(m_out.data.last_triangle)
);
